// File: rtl/mis_pkg.sv
// Package for the merge insertion sorter: transfer payload structs,
// the control word broadcast along the cell chain, and fixed field widths.
// No dependencies.
`default_nettype none

package mis_pkg;

  localparam int unsigned DATA_BITS = 32;

  typedef struct packed {
    logic [DATA_BITS-1:0] value;
    logic                 is_final;
  } in_item_t;

  typedef struct packed {
    logic [DATA_BITS-1:0] sorted_value;
    logic                 end_of_list;
    logic                 overflowed;
  } out_item_t;

  typedef struct packed {
    logic ins;
    logic shift;
  } cell_ctl_t;

endpackage

`default_nettype wire

// File: rtl/merge_insertion_sorter.sv
// Merge insertion sorter: a chain of CAPACITY cells kept in ascending order.
// A value transferred in is placed in its cell in that same cycle, so one
// value is taken per cycle while a list loads. From the cycle after the final
// transfer the chain drains from cell 0, one result per cycle unless out_stall
// holds it; input is stalled until the drain ends.
// Reset clears occupancy and the dropped flag; cell values stay unreset.
`default_nettype none

module merge_insertion_sorter
  import mis_pkg::*;
#(
  parameter int unsigned CAPACITY   = 64,
  parameter int unsigned VALUE_BITS = 32
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire in_item_t  in_data,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_item_t      out_data
);

  logic                  draining_r;
  logic                  draining_nxt;
  logic                  dropped_r;
  logic                  dropped_nxt;
  logic                  in_xfer;
  logic                  out_xfer;
  logic                  full;
  logic [VALUE_BITS-1:0] in_value;
  cell_ctl_t             ctl;

  logic                  gt_w    [CAPACITY];
  logic                  occ_w   [CAPACITY];
  logic [VALUE_BITS-1:0] value_w [CAPACITY];

  generate
    if (VALUE_BITS > DATA_BITS) begin : g_in_wide
      assign in_value = {{(VALUE_BITS-DATA_BITS){1'b0}}, in_data.value};
      assign out_data.sorted_value = value_w[0][DATA_BITS-1:0];
    end else if (VALUE_BITS == DATA_BITS) begin : g_in_same
      assign in_value = in_data.value;
      assign out_data.sorted_value = value_w[0];
    end else begin : g_in_narrow
      assign in_value = in_data.value[VALUE_BITS-1:0];
      assign out_data.sorted_value = {{(DATA_BITS-VALUE_BITS){1'b0}}, value_w[0]};
    end
  endgenerate

  assign in_stall  = draining_r;
  assign in_xfer   = in_valid && !in_stall;
  assign out_valid = draining_r;
  assign out_xfer  = out_valid && !out_stall;
  assign full      = occ_w[CAPACITY-1];

  assign ctl.ins   = in_xfer && !full;
  assign ctl.shift = out_xfer;

  assign out_data.end_of_list = !occ_w[1];
  assign out_data.overflowed  = dropped_r;

  generate
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic                  l_gt;
      logic                  l_occ;
      logic [VALUE_BITS-1:0] l_value;
      logic                  r_occ;
      logic [VALUE_BITS-1:0] r_value;

      if (i == 0) begin : g_head
        assign l_gt    = 1'b0;
        assign l_occ   = 1'b1;
        assign l_value = in_value;
      end else begin : g_body
        assign l_gt    = gt_w[i-1];
        assign l_occ   = occ_w[i-1];
        assign l_value = value_w[i-1];
      end

      if (i == CAPACITY-1) begin : g_tail
        assign r_occ   = 1'b0;
        assign r_value = value_w[i];
      end else begin : g_inner
        assign r_occ   = occ_w[i+1];
        assign r_value = value_w[i+1];
      end

      mis_cell #(
        .VALUE_BITS(VALUE_BITS)
      ) u_cell (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .in_value   (in_value),
        .left_gt    (l_gt),
        .left_occ   (l_occ),
        .left_value (l_value),
        .right_occ  (r_occ),
        .right_value(r_value),
        .gt         (gt_w[i]),
        .occ        (occ_w[i]),
        .value      (value_w[i])
      );
    end
  endgenerate

  always_comb begin
    draining_nxt = draining_r;
    dropped_nxt  = dropped_r;
    if (in_xfer) begin
      if (full) begin
        dropped_nxt = 1'b1;
      end
      if (in_data.is_final) begin
        draining_nxt = 1'b1;
      end
    end
    // last transfer of the list: end drain and drop the flag
    if (out_xfer && !occ_w[1]) begin
      draining_nxt = 1'b0;
      dropped_nxt  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      draining_r <= 1'b0;
      dropped_r  <= 1'b0;
    end else begin
      draining_r <= draining_nxt;
      dropped_r  <= dropped_nxt;
    end
  end

endmodule

`default_nettype wire

// File: rtl/mis_cell.sv
// One cell of the sorting chain: holds a single value and its occupancy.
// Depends on mis_pkg for the chain control word.
`default_nettype none

module mis_cell
  import mis_pkg::*;
#(
  parameter int unsigned VALUE_BITS = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire cell_ctl_t             ctl,
  input  wire logic [VALUE_BITS-1:0] in_value,
  input  wire logic                  left_gt,
  input  wire logic                  left_occ,
  input  wire logic [VALUE_BITS-1:0] left_value,
  input  wire logic                  right_occ,
  input  wire logic [VALUE_BITS-1:0] right_value,
  output logic                       gt,
  output logic                       occ,
  output logic [VALUE_BITS-1:0]      value
);

  logic                  occ_r;
  logic                  occ_nxt;
  logic [VALUE_BITS-1:0] value_r;
  logic [VALUE_BITS-1:0] value_nxt;

  // an empty cell counts as holding a value above everything
  assign gt    = !occ_r || (value_r > in_value);
  assign occ   = occ_r;
  assign value = value_r;

  always_comb begin
    occ_nxt   = occ_r;
    value_nxt = value_r;
    if (ctl.ins) begin
      if (gt) begin
        value_nxt = left_gt ? left_value : in_value;
        occ_nxt   = occ_r | left_occ;
      end
    end else if (ctl.shift) begin
      value_nxt = right_value;
      occ_nxt   = right_occ;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= 1'b0;
    end else begin
      occ_r <= occ_nxt;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

endmodule

`default_nettype wire

// File: test/testbench.sv
// Self-checking bench for merge_insertion_sorter: lists of values are streamed in, and each
// sorted drain is compared against a scoreboard that keeps its own ordered copy of each list.
// Depends on mis_pkg and the sorter RTL only.
`timescale 1ns / 100ps

module testbench;
  import mis_pkg::*;

  localparam int unsigned SORT_DEPTH = 64;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned IDLE_LIMIT = 4000;
  localparam int unsigned RANDOM_ITEMS = 100;

  class sort_scoreboard #(int unsigned DEPTH = 64);
    logic [DATA_BITS-1:0] held_q[$];
    bit                   dropped;
    out_item_t            drain_q[$];
    int unsigned          mismatches;

    function void note_input(in_item_t item);
      int unsigned pos;
      out_item_t   res;
      if (held_q.size() >= DEPTH) begin
        dropped = 1'b1;
      end else begin
        pos = 0;
        while (pos < held_q.size() && held_q[pos] <= item.value) pos++;
        held_q.insert(pos, item.value);
      end
      if (item.is_final) begin
        foreach (held_q[k]) begin
          res.sorted_value = held_q[k];
          res.end_of_list  = (k == held_q.size() - 1);
          res.overflowed   = dropped;
          drain_q.insert(drain_q.size(), res);
        end
        held_q.delete();
        dropped = 1'b0;
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (drain_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected transfer: value=%h end=%b ovf=%b",
                   got.sorted_value, got.end_of_list, got.overflowed);
      end else begin
        want = drain_q.pop_front();
        if (got.sorted_value !== want.sorted_value || got.end_of_list !== want.end_of_list ||
            got.overflowed !== want.overflowed) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected value=%h end=%b ovf=%b, got value=%h end=%b ovf=%b",
                     want.sorted_value, want.end_of_list, want.overflowed,
                     got.sorted_value, got.end_of_list, got.overflowed);
        end
      end
    endfunction

    function int unsigned pending();
      return drain_q.size();
    endfunction
  endclass

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  sort_scoreboard #(SORT_DEPTH) sb = new;

  int unsigned holds_asked = 0;
  int unsigned holds_done = 0;
  int unsigned rx_left = 0;
  bit          rx_hold = 1'b0;
  int unsigned idle_cycles = 0;
  int unsigned items_sent;

  merge_insertion_sorter #(
    .CAPACITY  (SORT_DEPTH),
    .VALUE_BITS(DATA_BITS)
  ) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
  end

  always @(posedge clk) begin
    if (rx_left == 0) begin
      if (holds_done != holds_asked) begin
        holds_done++;
        rx_hold = 1'b1;
        rx_left = HOLD_CYCLES;
      end else if ($urandom_range(0, 1) == 0) begin
        rx_hold = 1'b0;
        rx_left = $urandom_range(1, 30);
      end else begin
        rx_hold = 1'b1;
        rx_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
      end
    end
    rx_left--;
    out_stall <= rx_hold;
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  function automatic int unsigned pick_gap(bit dense);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (dense || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [DATA_BITS-1:0] pick_value();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    if (r < 5) return $urandom_range(0, 15);
    return $urandom();
  endfunction

  task automatic send_value(input logic [DATA_BITS-1:0] v, input bit fin,
                            input int unsigned gap);
    in_item_t item;
    item.value    = v;
    item.is_final = fin;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_stall);
    sb.note_input(item);
    items_sent++;
  endtask

  task automatic send_list(input int unsigned len, input bit dense);
    for (int unsigned k = 0; k < len; k++)
      send_value(pick_value(), k == len - 1, pick_gap(dense));
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  initial begin
    int unsigned len;
    items_sent = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // extremes, equal values, final on a duplicate
    send_value('1, 1'b0, 0);
    send_value('0, 1'b0, 1);
    send_value(32'd5, 1'b0, 0);
    send_value(32'd5, 1'b0, 0);
    send_value(32'h8000_0000, 1'b0, 2);
    send_value(32'd1, 1'b0, 0);
    send_value(32'd5, 1'b1, 0);
    wait_drained();
    // single-value lists
    send_value('0, 1'b1, 0);
    send_value('1, 1'b1, 0);
    // all equal
    send_value(32'd7, 1'b0, 0);
    send_value(32'd7, 1'b0, 0);
    send_value(32'd7, 1'b1, 0);
    // descending, alternating bit patterns
    send_value(32'hAAAA_AAAA, 1'b0, 0);
    send_value(32'h5555_5555, 1'b0, 0);
    send_value(32'h0000_FFFF, 1'b0, 0);
    send_value(32'h0000_0002, 1'b1, 0);
    wait_drained();

    // fill and overflow the store while the receiver holds off; the tail, final included,
    // is dropped and the second list stalls behind the drain
    holds_asked++;
    send_list(SORT_DEPTH + 2, 1'b1);
    send_list(5, 1'b1);
    wait_drained();
    // the list after an overflow must come out clean
    send_list(3, 1'b0);

    while (items_sent < RANDOM_ITEMS) begin
      len = ($urandom_range(0, 99) < 80) ? $urandom_range(1, 8) : $urandom_range(9, 24);
      send_list(len, $urandom_range(0, 3) == 0);
      if ($urandom_range(0, 4) == 0) wait_drained();
    end

    wait_drained();
    repeat (20) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// File: merge_insertion_sorter.f
rtl/mis_pkg.sv
rtl/mis_cell.sv
rtl/merge_insertion_sorter.sv
test/testbench.sv
